// ===== hw/rtl/smmla_pkg.sv =====
// shared constants and controller/datapath handshake types for the
// sample min/max leaky average block; no dependencies
`timescale 1ns / 1ps

package smmla_pkg;

	localparam int SAMPLE_WIDTH_DEF = 16;
	localparam int SUM_WIDTH_DEF    = 24;
	localparam int COUNT_W          = 8;
	localparam int APB_DATA_W       = 32;
	localparam int APB_ADDR_W       = 2;

	localparam logic [COUNT_W-1:0]    WINDOW_RESET    = 8'd10;
	localparam logic [APB_ADDR_W-1:0] REG_WINDOW_ADDR = 2'd0;

	typedef struct packed {
		logic load;
		logic div_step;
		logic finish;
	} smmla_cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_last;
		logic out_free;
	} smmla_sts_t;

endpackage

// ===== hw/rtl/smmla_sample_if.sv =====
// valid/ready channel carrying one input sample
// depends on smmla_pkg for the default width
`timescale 1ns / 1ps

interface smmla_sample_if #(
	parameter int SAMPLE_WIDTH = smmla_pkg::SAMPLE_WIDTH_DEF
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

// ===== hw/rtl/smmla_result_if.sv =====
// valid/ready channel carrying one result with all tracked values
// depends on smmla_pkg for default widths
`timescale 1ns / 1ps

interface smmla_result_if #(
	parameter int SAMPLE_WIDTH = smmla_pkg::SAMPLE_WIDTH_DEF,
	parameter int SUM_WIDTH    = smmla_pkg::SUM_WIDTH_DEF
);
	logic                              valid;
	logic                              ready;
	logic signed [SAMPLE_WIDTH-1:0]    last_value;
	logic signed [SAMPLE_WIDTH-1:0]    min_value;
	logic signed [SAMPLE_WIDTH-1:0]    max_value;
	logic signed [SUM_WIDTH-1:0]       leaky_sum;
	logic [smmla_pkg::COUNT_W-1:0]     sample_count;

	modport source (
		output valid, output last_value, output min_value, output max_value,
		output leaky_sum, output sample_count, input ready
	);
	modport sink (
		input valid, input last_value, input min_value, input max_value,
		input leaky_sum, input sample_count, output ready
	);
endinterface

// ===== hw/rtl/smmla_ctrl.sv =====
// controller state machine: accept, serial divide when needed, finish into result register
// depends on smmla_pkg for the command and status structs
`timescale 1ns / 1ps

module smmla_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  smmla_pkg::smmla_sts_t  sts,
	output smmla_pkg::smmla_cmd_t  cmd
);
	import smmla_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next   = state_q;
		in_ready     = 1'b0;
		cmd.load     = 1'b0;
		cmd.div_step = 1'b0;
		cmd.finish   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load   = 1'b1;
					state_next = sts.need_div ? ST_DIV : ST_FIN;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_next = ST_FIN;
				end
			end
			ST_FIN: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== hw/rtl/smmla_dp.sv =====
// datapath: tracked state, restoring divider by the count, saturating add,
// result register; depends on smmla_pkg
`timescale 1ns / 1ps

module smmla_dp #(
	parameter int SAMPLE_WIDTH = smmla_pkg::SAMPLE_WIDTH_DEF,
	parameter int SUM_WIDTH    = smmla_pkg::SUM_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  smmla_pkg::smmla_cmd_t             cmd,
	output smmla_pkg::smmla_sts_t             sts,
	input  logic signed [SAMPLE_WIDTH-1:0]    sample,
	input  logic [smmla_pkg::COUNT_W-1:0]     window,
	input  logic                              res_ready,
	output logic                              res_valid,
	output logic signed [SAMPLE_WIDTH-1:0]    last_value,
	output logic signed [SAMPLE_WIDTH-1:0]    min_value,
	output logic signed [SAMPLE_WIDTH-1:0]    max_value,
	output logic signed [SUM_WIDTH-1:0]       leaky_sum,
	output logic [smmla_pkg::COUNT_W-1:0]     sample_count
);
	import smmla_pkg::*;

	localparam int CNT_W = $clog2(SUM_WIDTH + 1);
	localparam int EXT_W = ((SAMPLE_WIDTH > SUM_WIDTH) ? SAMPLE_WIDTH : SUM_WIDTH) + 1;

	localparam logic signed [SAMPLE_WIDTH-1:0] MIN_RESET = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam logic signed [SUM_WIDTH-1:0]    SUM_MAX   = {1'b0, {(SUM_WIDTH-1){1'b1}}};
	localparam logic signed [SUM_WIDTH-1:0]    SUM_MIN   = {1'b1, {(SUM_WIDTH-1){1'b0}}};

	logic signed [SAMPLE_WIDTH-1:0] last_q, min_q, max_q, sample_q;
	logic signed [SUM_WIDTH-1:0]    sum_q;
	logic [COUNT_W-1:0]             count_q;
	logic                           need_div_q, neg_q, res_valid_q;
	logic [COUNT_W-1:0]             rem_q;
	logic [SUM_WIDTH-1:0]           quo_q;
	logic [CNT_W-1:0]               cnt_q;

	logic                           count_below;
	logic [SUM_WIDTH-1:0]           sum_mag;
	logic [COUNT_W:0]               trial, diff;
	logic signed [SUM_WIDTH-1:0]    dec;
	logic signed [EXT_W-1:0]        acc;
	logic signed [SUM_WIDTH-1:0]    sat;

	assign count_below  = count_q < window;
	assign sum_mag      = sum_q[SUM_WIDTH-1] ? -sum_q : sum_q;
	assign sts.need_div = !count_below && (count_q != '0);
	assign sts.div_last = cnt_q == CNT_W'(1);
	assign sts.out_free = !res_valid_q || res_ready;

	// one quotient bit per step
	assign trial = {rem_q, quo_q[SUM_WIDTH-1]};
	assign diff  = trial - {1'b0, count_q};

	// sum minus sum/count (truncated toward zero) when dividing, plus the sample, saturated
	always_comb begin
		if (!need_div_q) begin
			dec = sum_q;
		end else if (neg_q) begin
			dec = sum_q + signed'(quo_q);
		end else begin
			dec = sum_q - signed'(quo_q);
		end
		acc = signed'({{(EXT_W-SUM_WIDTH){dec[SUM_WIDTH-1]}}, dec})
			+ signed'({{(EXT_W-SAMPLE_WIDTH){sample_q[SAMPLE_WIDTH-1]}}, sample_q});
		if (acc[EXT_W-1:SUM_WIDTH-1] == '0 || acc[EXT_W-1:SUM_WIDTH-1] == '1) begin
			sat = acc[SUM_WIDTH-1:0];
		end else if (acc[EXT_W-1]) begin
			sat = SUM_MIN;
		end else begin
			sat = SUM_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q      <= '0;
			min_q       <= MIN_RESET;
			max_q       <= '0;
			sum_q       <= '0;
			count_q     <= '0;
			need_div_q  <= 1'b0;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				last_q     <= sample;
				need_div_q <= sts.need_div;
				cnt_q      <= CNT_W'(SUM_WIDTH);
				if (sample > max_q) begin
					max_q <= sample;
				end
				if (sample < min_q) begin
					min_q <= sample;
				end
				if (count_below) begin
					count_q <= count_q + COUNT_W'(1);
				end
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (cmd.finish) begin
				sum_q       <= sat;
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sample_q <= sample;
			neg_q    <= sum_q[SUM_WIDTH-1];
			quo_q    <= sum_mag;
			rem_q    <= '0;
		end else if (cmd.div_step) begin
			if (!diff[COUNT_W]) begin
				rem_q <= diff[COUNT_W-1:0];
				quo_q <= {quo_q[SUM_WIDTH-2:0], 1'b1};
			end else begin
				rem_q <= trial[COUNT_W-1:0];
				quo_q <= {quo_q[SUM_WIDTH-2:0], 1'b0};
			end
		end
		if (cmd.finish) begin
			last_value   <= last_q;
			min_value    <= min_q;
			max_value    <= max_q;
			leaky_sum    <= sat;
			sample_count <= count_q;
		end
	end

	assign res_valid = res_valid_q;

	a_finish_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!res_valid_q || res_ready))
		else $error("result register overwritten while still pending");

	a_count_steps: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (count_q == $past(count_q) || count_q == $past(count_q) + COUNT_W'(1)))
		else $error("sample count moved by more than one");

	a_max_floor: assert property (@(posedge clk) disable iff (!arst_n)
		!max_q[SAMPLE_WIDTH-1])
		else $error("running maximum fell below zero");

	a_div_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> cnt_q != '0)
		else $error("divider stepped past its last bit");

endmodule

// ===== hw/rtl/sample_min_max_leaky_average.sv =====
// Sample min/max leaky average. Each accepted sample updates the last value, the running
// minimum and maximum, a count capped at the window register and a leaky sum that loses
// sum/count per sample once the count has reached the window. While the count is still
// filling, an item goes from accept straight to finish; once the sum decays it first passes
// through the restoring divider, which retires one quotient bit per cycle.
// Results wait in an output register, so the next sample is accepted while one is pending.
// top level: apb window register, controller and datapath; uses smmla_pkg, smmla_ctrl,
// smmla_dp and the two channel interfaces
`timescale 1ns / 1ps

module sample_min_max_leaky_average #(
	parameter int SAMPLE_WIDTH = smmla_pkg::SAMPLE_WIDTH_DEF,
	parameter int SUM_WIDTH    = smmla_pkg::SUM_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	smmla_sample_if.sink                       samples,
	smmla_result_if.source                     results,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [smmla_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [smmla_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [smmla_pkg::APB_DATA_W-1:0]   prdata,
	output logic                               pready
);
	import smmla_pkg::*;

	logic [COUNT_W-1:0] window_q;
	smmla_cmd_t         cmd;
	smmla_sts_t         sts;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
		end else if (psel && penable && pwrite && pready && paddr == REG_WINDOW_ADDR) begin
			window_q <= pwdata[COUNT_W-1:0];
		end
	end

	assign prdata = (paddr == REG_WINDOW_ADDR) ? APB_DATA_W'(window_q) : '0;

	smmla_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samples.valid),
		.in_ready (samples.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	smmla_dp #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.SUM_WIDTH    (SUM_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.sample       (samples.sample),
		.window       (window_q),
		.res_ready    (results.ready),
		.res_valid    (results.valid),
		.last_value   (results.last_value),
		.min_value    (results.min_value),
		.max_value    (results.max_value),
		.leaky_sum    (results.leaky_sum),
		.sample_count (results.sample_count)
	);

endmodule
